// ===== hdl/ws2812_frame_spi_encoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// WS2812 frame SPI encoder assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef WS2812_FRAME_SPI_ENCODER_TOP_DEFINES_SVH
`define WS2812_FRAME_SPI_ENCODER_TOP_DEFINES_SVH

// same-cycle implication
`define WFSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WFSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wfse_pkg.sv =====
// ----------------------------------------------------------------------------
// WS2812 frame SPI encoder package
// Sizes, command codes, state types and the line-encoding functions.
// ----------------------------------------------------------------------------
package wfse_pkg;

  localparam int MAX_PIXELS      = 1024;
  localparam int ADDR_W          = $clog2(MAX_PIXELS);
  localparam int CNT_W           = 11;
  localparam int PIX_W           = 24;
  localparam int CHAN_W          = 8;
  localparam int FUNC_W          = 3;
  localparam int RESET_BYTES     = 20;
  localparam int RCNT_W          = 5;
  localparam int BYTES_PER_PIXEL = 9;
  localparam int BIP_W           = 4;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd64;

  localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FILL  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEND  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_BURST = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd4;

  localparam logic [2:0] LINE_ONE  = 3'b110;
  localparam logic [2:0] LINE_ZERO = 3'b100;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_RESET = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_READ
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear_run;
    logic fill_run;
    logic emit_read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic start_fill;
    logic start_read;
    logic clear_last;
    logic fill_last;
  } ctrl_sts_t;

  function automatic logic [PIX_W-1:0] encode_channel(input logic [CHAN_W-1:0] v);
    logic [PIX_W-1:0] enc;
    for (int i = 0; i < CHAN_W; i++) begin
      enc[3*i +: 3] = v[i] ? LINE_ONE : LINE_ZERO;
    end
    return enc;
  endfunction

  // rgb packed as red[23:16], green[15:8], blue[7:0]; sent green, red, blue
  function automatic logic [CHAN_W-1:0] frame_byte(input logic [PIX_W-1:0] rgb,
                                                   input logic [BIP_W-1:0] k);
    logic [CHAN_W-1:0] val;
    logic [PIX_W-1:0]  enc;
    logic [CHAN_W-1:0] res;
    case (k) inside
      [4'd0:4'd2]: val = rgb[15:8];
      [4'd3:4'd5]: val = rgb[23:16];
      default:     val = rgb[7:0];
    endcase
    enc = encode_channel(val);
    case (k) inside
      4'd0, 4'd3, 4'd6: res = enc[23:16];
      4'd1, 4'd4, 4'd7: res = enc[15:8];
      default:          res = enc[7:0];
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/wfse_ram.sv =====
// ----------------------------------------------------------------------------
// WFSE generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wfse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/wfse_ctrl.sv =====
// ----------------------------------------------------------------------------
// WFSE controller
// Sequences the clear sweep, fill sweep, frame reads and item acceptance.
// ----------------------------------------------------------------------------
module wfse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wfse_pkg::ctrl_sts_t sts,
  output wfse_pkg::ctrl_cmd_t cmd
);
  import wfse_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && sts.out_free) begin
          if (sts.start_fill) state_nxt = ST_FILL;
          else if (sts.start_read) state_nxt = ST_READ;
        end
      end
      ST_FILL: begin
        if (sts.fill_last) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clear_run = 1'b1;
      ST_IDLE: begin
        in_stall   = !sts.out_free;
        cmd.accept = in_valid && sts.out_free;
      end
      ST_FILL: cmd.fill_run  = 1'b1;
      ST_READ: cmd.emit_read = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/wfse_datapath.sv =====
// ----------------------------------------------------------------------------
// WFSE datapath
// Frame store, send counters, pixel count register and result register.
// ----------------------------------------------------------------------------
module wfse_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  wfse_pkg::ctrl_cmd_t                    cmd,
  output wfse_pkg::ctrl_sts_t                    sts,
  input  logic [wfse_pkg::FUNC_W-1:0]            in_func,
  input  logic [wfse_pkg::ADDR_W-1:0]            in_pixel_index,
  input  logic [wfse_pkg::CHAN_W-1:0]            in_red,
  input  logic [wfse_pkg::CHAN_W-1:0]            in_green,
  input  logic [wfse_pkg::CHAN_W-1:0]            in_blue,
  input  logic                                   cfg_we,
  input  logic [wfse_pkg::CNT_W-1:0]             cfg_wdata,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_byte_valid,
  output logic [wfse_pkg::CHAN_W-1:0]            out_spi_byte,
  output logic                                   out_last_byte,
  output logic                                   out_busy_res,
  output logic                                   out_rejected
);
  import wfse_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [ADDR_W-1:0]  cursor_r, cursor_nxt;
  logic [BIP_W-1:0]   bip_r, bip_nxt;
  logic [RCNT_W-1:0]  rcnt_r, rcnt_nxt;
  logic [ADDR_W-1:0]  sweep_r, sweep_nxt;
  logic [CNT_W-1:0]   pixel_count_r, pixel_count_nxt;
  logic [PIX_W-1:0]   fill_rgb_r, fill_rgb_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               o_bv_r, o_last_r, o_busy_r, o_rej_r;
  logic [CHAN_W-1:0]  o_byte_r;

  logic               ld;
  logic               o_bv, o_last, o_rej;
  logic [CHAN_W-1:0]  o_byte;
  logic [CNT_W-1:0]   count_use;
  logic [ADDR_W-1:0]  count_m1;
  logic [PIX_W-1:0]   in_rgb;
  logic               busy;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [PIX_W-1:0]   ram_wdata;
  logic [PIX_W-1:0]   ram_rdata;

  wfse_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cursor_r),
    .rdata (ram_rdata)
  );

  assign in_rgb = {in_red, in_green, in_blue};
  assign busy   = (mode_r != MODE_IDLE);

  always_comb begin
    if (pixel_count_r == '0) begin
      count_use = CNT_W'(1);
    end else if (pixel_count_r > CNT_W'(MAX_PIXELS)) begin
      count_use = CNT_W'(MAX_PIXELS);
    end else begin
      count_use = pixel_count_r;
    end
  end

  assign count_m1 = ADDR_W'(count_use - CNT_W'(1));

  always_comb begin
    sts.out_free   = !out_valid_r || !out_stall;
    sts.start_fill = (in_func == FUNC_FILL) && !busy;
    sts.start_read = (in_func == FUNC_TICK) && (mode_r == MODE_FRAME);
    sts.clear_last = (sweep_r == ADDR_W'(MAX_PIXELS - 1));
    sts.fill_last  = (sweep_r == count_m1);
  end

  always_comb begin
    mode_nxt        = mode_r;
    cursor_nxt      = cursor_r;
    bip_nxt         = bip_r;
    rcnt_nxt        = rcnt_r;
    sweep_nxt       = sweep_r;
    fill_rgb_nxt    = fill_rgb_r;
    pixel_count_nxt = pixel_count_r;
    ram_we          = 1'b0;
    ram_waddr       = sweep_r;
    ram_wdata       = fill_rgb_r;
    ld              = 1'b0;
    o_bv            = 1'b0;
    o_byte          = '0;
    o_last          = 1'b0;
    o_rej           = 1'b0;

    if (cfg_we && !busy) begin
      pixel_count_nxt = cfg_wdata;
    end

    if (cmd.clear_run) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
      sweep_nxt = sweep_r + ADDR_W'(1);
    end

    if (cmd.fill_run) begin
      ram_we    = 1'b1;
      sweep_nxt = sweep_r + ADDR_W'(1);
    end

    if (cmd.emit_read) begin
      ld     = 1'b1;
      o_bv   = 1'b1;
      o_byte = frame_byte(ram_rdata, bip_r);
      if (bip_r == BIP_W'(BYTES_PER_PIXEL - 1)) begin
        bip_nxt = '0;
        if (({1'b0, cursor_r} + CNT_W'(1)) >= count_use) begin
          o_last     = 1'b1;
          mode_nxt   = MODE_IDLE;
          cursor_nxt = '0;
        end else begin
          cursor_nxt = cursor_r + ADDR_W'(1);
        end
      end else begin
        bip_nxt = bip_r + BIP_W'(1);
      end
    end

    if (cmd.accept) begin
      ld = 1'b1;
      unique case (in_func)
        FUNC_SET: begin
          if (busy || ({1'b0, in_pixel_index} >= count_use)) begin
            o_rej = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = in_pixel_index;
            ram_wdata = in_rgb;
          end
        end
        FUNC_FILL: begin
          if (busy) begin
            o_rej = 1'b1;
          end else begin
            sweep_nxt    = '0;
            fill_rgb_nxt = in_rgb;
          end
        end
        FUNC_SEND: begin
          if (busy) begin
            o_rej = 1'b1;
          end else begin
            mode_nxt   = MODE_FRAME;
            cursor_nxt = '0;
            bip_nxt    = '0;
          end
        end
        FUNC_BURST: begin
          if (busy) begin
            o_rej = 1'b1;
          end else begin
            mode_nxt = MODE_RESET;
            rcnt_nxt = '0;
          end
        end
        FUNC_TICK: begin
          unique case (mode_r)
            MODE_FRAME: ld = 1'b0;
            MODE_RESET: begin
              o_bv = 1'b1;
              if (rcnt_r == RCNT_W'(RESET_BYTES - 1)) begin
                o_last   = 1'b1;
                mode_nxt = MODE_IDLE;
                rcnt_nxt = '0;
              end else begin
                rcnt_nxt = rcnt_r + RCNT_W'(1);
              end
            end
            default: o_bv = 1'b0;
          endcase
        end
        default: o_rej = 1'b1;
      endcase
    end

    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      cursor_r      <= '0;
      bip_r         <= '0;
      rcnt_r        <= '0;
      sweep_r       <= '0;
      pixel_count_r <= COUNT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      cursor_r      <= cursor_nxt;
      bip_r         <= bip_nxt;
      rcnt_r        <= rcnt_nxt;
      sweep_r       <= sweep_nxt;
      pixel_count_r <= pixel_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_rgb_r <= fill_rgb_nxt;
    if (ld) begin
      o_bv_r   <= o_bv;
      o_byte_r <= o_byte;
      o_last_r <= o_last;
      o_busy_r <= (mode_nxt != MODE_IDLE);
      o_rej_r  <= o_rej;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_valid = o_bv_r;
  assign out_spi_byte   = o_byte_r;
  assign out_last_byte  = o_last_r;
  assign out_busy_res   = o_busy_r;
  assign out_rejected   = o_rej_r;

endmodule

// ===== hdl/ws2812_frame_spi_encoder_top.sv =====
// Results are registered and valid in the cycle after the transfer; a tick during a frame
// send first passes through the read state (store read port). One item per cycle while
// the output is not stalled and no fill or frame read runs; a fill writes one store
// entry per cycle. Reset: synchronous, active low; a clearing pass then writes the
// 1024-entry store to black with input held stalled. Pixel count resets to 64.
// ----------------------------------------------------------------------------
// WS2812 frame SPI encoder top level
// Pixel frame store streamed as 3-bit-per-bit SPI line bytes.
// ----------------------------------------------------------------------------
module ws2812_frame_spi_encoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wfse_pkg::FUNC_W-1:0]   in_func,
  input  logic [wfse_pkg::ADDR_W-1:0]   in_pixel_index,
  input  logic [wfse_pkg::CHAN_W-1:0]   in_red,
  input  logic [wfse_pkg::CHAN_W-1:0]   in_green,
  input  logic [wfse_pkg::CHAN_W-1:0]   in_blue,
  input  logic                          cfg_we,
  input  logic [wfse_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_byte_valid,
  output logic [wfse_pkg::CHAN_W-1:0]   out_spi_byte,
  output logic                          out_last_byte,
  output logic                          out_busy_res,
  output logic                          out_rejected
);
  import wfse_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  wfse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wfse_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_pixel_index (in_pixel_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_valid (out_byte_valid),
    .out_spi_byte   (out_spi_byte),
    .out_last_byte  (out_last_byte),
    .out_busy_res   (out_busy_res),
    .out_rejected   (out_rejected)
  );

endmodule

// ===== hdl/wfse_checker.sv =====
// ----------------------------------------------------------------------------
// WFSE port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ws2812_frame_spi_encoder_top_defines.svh"

module wfse_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_byte_valid,
  input logic [wfse_pkg::CHAN_W-1:0]   out_spi_byte,
  input logic                          out_last_byte,
  input logic                          out_busy_res,
  input logic                          out_rejected
);

  `WFSE_ASSERT_IMP(a_no_byte_is_zero, out_valid && !out_byte_valid,
                   out_spi_byte == '0 && !out_last_byte, "byte without byte_valid")
  `WFSE_ASSERT_IMP(a_last_ends_send, out_valid && out_last_byte,
                   out_byte_valid && !out_busy_res, "last byte left block busy")
  `WFSE_ASSERT_IMP(a_reject_no_byte, out_valid && out_rejected,
                   !out_byte_valid, "rejected transfer carried a byte")
  `WFSE_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_spi_byte), "stalled result changed")

endmodule

bind ws2812_frame_spi_encoder_top wfse_checker u_wfse_checker (.*);

// ===== tb/tb_ws2812_frame_spi_encoder_top.sv =====
// ----------------------------------------------------------------------------
// WS2812 frame SPI encoder testbench
// Drives commands into the encoder and checks every result in order against a
// behavioral model of the pixel store and the line-byte sequencer. A short
// stimulus table comes first, then phases of random command sequences at
// several pixel counts, with random stalls, a long output hold-off and
// fills at the largest count.
// ----------------------------------------------------------------------------
module tb_ws2812_frame_spi_encoder_top;
  import wfse_pkg::*;

  localparam int IDLE_PCT     = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = MAX_PIXELS + 16;
  localparam int TAIL_CYCLES  = 8;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_ITEMS  = 150;
  localparam int SEND_LIMIT   = 64;
  localparam int RESET_CYCLES = 7;
  localparam int LIMIT_TIME   = 2_000_000;

  localparam logic [FUNC_W-1:0] FUNC_RSV_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSV_HI = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] idx;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } cmd_t;

  typedef struct packed {
    logic              byte_valid;
    logic [CHAN_W-1:0] spi_byte;
    logic              last_byte;
    logic              busy;
    logic              rejected;
  } enc_result_t;

  typedef struct packed {
    logic             is_cfg;
    logic [CNT_W-1:0] cfg_val;
    cmd_t             cmd;
    logic [4:0]       reps;
    logic             typed;
    enc_result_t      want;
  } step_t;

  localparam enc_result_t R_IDLE     = '0;
  localparam enc_result_t R_REJ      = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1};
  localparam enc_result_t R_BUSY     = '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
  localparam enc_result_t R_BUSY_REJ = '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1};
  localparam enc_result_t R_GRN_HI   = '{1'b1, 8'hDB, 1'b0, 1'b1, 1'b0};
  localparam enc_result_t R_BLU_LAST = '{1'b1, 8'h24, 1'b1, 1'b0, 1'b0};

  localparam int PLAN_LEN = 21;
  localparam step_t PLAN [0:PLAN_LEN-1] = '{
    '{1'b0, 11'd0, '{FUNC_TICK, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd1, 1'b1, R_IDLE},
    '{1'b0, 11'd0, '{FUNC_SET, 10'd63, 8'hFF, 8'h00, 8'h55}, 5'd1, 1'b1, R_IDLE},
    '{1'b0, 11'd0, '{FUNC_SET, 10'd64, 8'h12, 8'h34, 8'h56}, 5'd1, 1'b1, R_REJ},
    '{1'b0, 11'd0, '{FUNC_SET, 10'd1023, 8'hFF, 8'hFF, 8'hFF}, 5'd1, 1'b1, R_REJ},
    '{1'b0, 11'd0, '{FUNC_RSV_LO, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd1, 1'b1, R_REJ},
    '{1'b0, 11'd0, '{FUNC_RSV_HI, 10'h3FF, 8'hFF, 8'hFF, 8'hFF}, 5'd1, 1'b1, R_REJ},
    '{1'b1, 11'd0, '0, 5'd0, 1'b0, R_IDLE},
    '{1'b0, 11'd0, '{FUNC_SET, 10'd1, 8'hAA, 8'hBB, 8'hCC}, 5'd1, 1'b1, R_REJ},
    '{1'b0, 11'd0, '{FUNC_FILL, 10'd0, 8'hFF, 8'h00, 8'hFF}, 5'd1, 1'b1, R_IDLE},
    '{1'b0, 11'd0, '{FUNC_SET, 10'd0, 8'h00, 8'hFF, 8'h80}, 5'd1, 1'b1, R_IDLE},
    '{1'b0, 11'd0, '{FUNC_SEND, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd1, 1'b1, R_BUSY},
    '{1'b0, 11'd0, '{FUNC_SEND, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd1, 1'b1, R_BUSY_REJ},
    '{1'b0, 11'd0, '{FUNC_FILL, 10'd0, 8'h11, 8'h22, 8'h33}, 5'd1, 1'b1, R_BUSY_REJ},
    '{1'b0, 11'd0, '{FUNC_BURST, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd1, 1'b1, R_BUSY_REJ},
    '{1'b0, 11'd0, '{FUNC_TICK, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd1, 1'b1, R_GRN_HI},
    '{1'b0, 11'd0, '{FUNC_TICK, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd7, 1'b0, R_IDLE},
    '{1'b0, 11'd0, '{FUNC_TICK, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd1, 1'b1, R_BLU_LAST},
    '{1'b0, 11'd0, '{FUNC_TICK, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd1, 1'b1, R_IDLE},
    '{1'b0, 11'd0, '{FUNC_BURST, 10'd0, 8'h00, 8'h00, 8'h00}, 5'd1, 1'b1, R_BUSY},
    '{1'b1, 11'h7FF, '0, 5'd0, 1'b0, R_IDLE},
    '{1'b0, 11'd0, '{FUNC_SET, 10'd0, 8'h01, 8'h02, 8'h03}, 5'd1, 1'b1, R_BUSY_REJ}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [ADDR_W-1:0] in_pixel_index = '0;
  logic [CHAN_W-1:0] in_red = '0;
  logic [CHAN_W-1:0] in_green = '0;
  logic [CHAN_W-1:0] in_blue = '0;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_byte_valid;
  logic [CHAN_W-1:0] out_spi_byte;
  logic              out_last_byte;
  logic              out_busy_res;
  logic              out_rejected;

  // model state
  logic [PIX_W-1:0] pixel_mirror [MAX_PIXELS];
  mode_t            line_mode;
  int unsigned      send_pixel;
  int unsigned      send_byte;
  int unsigned      burst_sent;
  logic [CNT_W-1:0] count_reg;

  enc_result_t pending_results[$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned errors;
  bit          calm;
  bit          hold_req;

  ws2812_frame_spi_encoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_pixel_index (in_pixel_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_valid (out_byte_valid),
    .out_spi_byte   (out_spi_byte),
    .out_last_byte  (out_last_byte),
    .out_busy_res   (out_busy_res),
    .out_rejected   (out_rejected)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #LIMIT_TIME;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR result %0d: %s", results_seen, msg);
    errors++;
  endtask

  function automatic int unsigned frame_len();
    if (count_reg == '0) return 1;
    if (count_reg > MAX_PIXELS) return MAX_PIXELS;
    return 32'(count_reg);
  endfunction

  function automatic enc_result_t apply_command(input cmd_t c);
    enc_result_t       r;
    int unsigned       n;
    int unsigned       p;
    logic              sending;
    logic [PIX_W-1:0]  stored;
    logic [PIX_W-1:0]  code;
    logic [CHAN_W-1:0] chan;
    r = '0;
    n = frame_len();
    sending = (line_mode != MODE_IDLE);
    case (c.func)
      FUNC_SET: begin
        if (sending || c.idx >= n) r.rejected = 1'b1;
        else pixel_mirror[c.idx] = {c.red, c.green, c.blue};
      end
      FUNC_FILL: begin
        if (sending) r.rejected = 1'b1;
        else for (int i = 0; i < n; i++) pixel_mirror[i] = {c.red, c.green, c.blue};
      end
      FUNC_SEND: begin
        if (sending) r.rejected = 1'b1;
        else begin
          line_mode = MODE_FRAME;
          send_pixel = 0;
          send_byte = 0;
        end
      end
      FUNC_BURST: begin
        if (sending) r.rejected = 1'b1;
        else begin
          line_mode = MODE_RESET;
          burst_sent = 0;
        end
      end
      FUNC_TICK: begin
        if (line_mode == MODE_FRAME) begin
          p = (send_pixel < n) ? send_pixel : n - 1;
          stored = pixel_mirror[p];
          case (send_byte / 3)
            0: chan = stored[15:8];
            1: chan = stored[23:16];
            default: chan = stored[7:0];
          endcase
          code = '0;
          for (int b = CHAN_W - 1; b >= 0; b--)
            code = {code[PIX_W-4:0], chan[b] ? LINE_ONE : LINE_ZERO};
          r.byte_valid = 1'b1;
          r.spi_byte = code[(2 - send_byte % 3) * 8 +: 8];
          send_byte++;
          if (send_byte >= BYTES_PER_PIXEL) begin
            send_byte = 0;
            send_pixel++;
            if (send_pixel >= n) begin
              r.last_byte = 1'b1;
              line_mode = MODE_IDLE;
              send_pixel = 0;
            end
          end
        end else if (line_mode == MODE_RESET) begin
          r.byte_valid = 1'b1;
          burst_sent++;
          if (burst_sent >= RESET_BYTES) begin
            r.last_byte = 1'b1;
            line_mode = MODE_IDLE;
            burst_sent = 0;
          end
        end
      end
      default: r.rejected = 1'b1;
    endcase
    r.busy = (line_mode != MODE_IDLE);
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] any_idx();
    return ADDR_W'($urandom_range(0, MAX_PIXELS - 1));
  endfunction

  task automatic put_item(input cmd_t c, input bit typed, input enc_result_t want);
    enc_result_t predicted;
    if (!calm)
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid       <= 1'b1;
    in_func        <= c.func;
    in_pixel_index <= c.idx;
    in_red         <= c.red;
    in_green       <= c.green;
    in_blue        <= c.blue;
    do @(posedge clk); while (in_stall);
    predicted = apply_command(c);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic issue(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] idx);
    cmd_t c;
    c.func  = f;
    c.idx   = idx;
    c.red   = rand_chan();
    c.green = rand_chan();
    c.blue  = rand_chan();
    put_item(c, 1'b0, R_IDLE);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ignored by the block while a frame or burst is in progress
  task automatic write_count(input logic [CNT_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    if (line_mode == MODE_IDLE) count_reg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic tick_until_idle();
    while (line_mode != MODE_IDLE) begin
      if ($urandom_range(15) == 0) issue(FUNC_W'($urandom_range(0, FUNC_BURST)), any_idx());
      else issue(FUNC_TICK, any_idx());
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count_value, input int unsigned n_items,
                           input bit finish, input bit hold);
    int unsigned       stop;
    int unsigned       n;
    logic [FUNC_W-1:0] f;
    write_count(count_value);
    if (hold) hold_req = 1'b1;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      n = frame_len();
      case ($urandom_range(9))
        0, 1: begin
          repeat ($urandom_range(1, 4))
            issue(FUNC_SET, ($urandom_range(9) == 0) ? any_idx()
                                                      : ADDR_W'($urandom_range(0, n - 1)));
        end
        2: issue(FUNC_FILL, any_idx());
        3, 4, 5: begin
          if (n <= SEND_LIMIT) begin
            issue(FUNC_SEND, any_idx());
            tick_until_idle();
          end else begin
            issue(FUNC_SET, ADDR_W'($urandom_range(0, n - 1)));
          end
        end
        6, 7: begin
          issue(FUNC_BURST, any_idx());
          tick_until_idle();
        end
        8: begin
          f = FUNC_W'($urandom_range(0, 7));
          if (f == FUNC_SEND && n > SEND_LIMIT) f = FUNC_TICK;
          issue(f, any_idx());
        end
        default: repeat ($urandom_range(1, 3)) issue(FUNC_TICK, any_idx());
      endcase
    end
    if (finish) tick_until_idle();
    else if (line_mode == MODE_IDLE) begin
      issue(FUNC_BURST, '0);
      repeat (3) issue(FUNC_TICK, '0);
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    enc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command pending");
      end else begin
        want = pending_results.pop_front();
        if (out_byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid got %0b expected %0b",
                                    out_byte_valid, want.byte_valid));
        if (out_spi_byte !== want.spi_byte)
          report_mismatch($sformatf("spi_byte got %02h expected %02h",
                                    out_spi_byte, want.spi_byte));
        if (out_last_byte !== want.last_byte)
          report_mismatch($sformatf("last_byte got %0b expected %0b",
                                    out_last_byte, want.last_byte));
        if (out_busy_res !== want.busy)
          report_mismatch($sformatf("busy_res got %0b expected %0b", out_busy_res, want.busy));
        if (out_rejected !== want.rejected)
          report_mismatch($sformatf("rejected got %0b expected %0b",
                                    out_rejected, want.rejected));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    int unsigned rand_base;
    for (int i = 0; i < MAX_PIXELS; i++) pixel_mirror[i] = '0;
    line_mode  = MODE_IDLE;
    send_pixel = 0;
    send_byte  = 0;
    burst_sent = 0;
    count_reg  = COUNT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) write_count(PLAN[i].cfg_val);
      else repeat (PLAN[i].reps) put_item(PLAN[i].cmd, PLAN[i].typed, PLAN[i].want);
    end

    // largest count: fill and the top pixel
    tick_until_idle();
    write_count('1);
    issue(FUNC_FILL, '0);
    issue(FUNC_SET, ADDR_W'(MAX_PIXELS - 1));

    rand_base = items_sent;
    run_phase(11'd3, PHASE_ITEMS, 1'b1, 1'b0);
    calm = 1'b1;
    run_phase(11'd0, PHASE_ITEMS, 1'b1, 1'b0);
    calm = 1'b0;
    run_phase(11'd5, PHASE_ITEMS, 1'b0, 1'b1);
    run_phase(11'd2, PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(11'd64, PHASE_ITEMS, 1'b1, 1'b0);
    run_phase(11'd1025, 80, 1'b1, 1'b0);
    run_phase(11'd1024, 60, 1'b1, 1'b0);
    run_phase(11'd1, PHASE_ITEMS, 1'b0, 1'b0);
    while (items_sent - rand_base < RANDOM_ITEMS)
      run_phase(CNT_W'($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 12)), PHASE_ITEMS,
                $urandom_range(1) != 0, 1'b0);
    tick_until_idle();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
